// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/kmp_pkg.sv -----
// ----------------------------------------------------------------------------
// KMP search package
// Widths, register indexes and sizes shared by the search block files.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 4;
    localparam int PAT_W       = MAX_PATTERN * BYTE_W;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);

endpackage

// ----- hdl/kmp_if.sv -----
// ----------------------------------------------------------------------------
// KMP search channels
// Valid/ready channels for text bytes, results and register writes.
// ----------------------------------------------------------------------------
interface kmp_text_if;
    import kmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_of_text;
    modport source (output valid, output text_byte, output last_of_text, input ready);
    modport sink   (input valid, input text_byte, input last_of_text, output ready);
endinterface

interface kmp_result_if;
    logic valid;
    logic ready;
    logic found;
    logic text_done;
    modport source (output valid, output found, output text_done, input ready);
    modport sink   (input valid, input found, input text_done, output ready);
endinterface

interface kmp_cfg_if;
    import kmp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/kmp_substring_match.sv -----
// ----------------------------------------------------------------------------
// KMP substring match
// Streams text bytes against a configured pattern with a sticky found flag.
// ----------------------------------------------------------------------------
// Searches each text for a pattern of up to MAX_PATTERN bytes, one result per
// text byte. On the first byte of a text the pattern registers are copied and
// the fallback table is built; every byte then walks the table until it
// extends the match or reaches length zero. A single 8-bit byte comparator and
// one table read port are shared by the build and search steps, so timing
// follows the fallback walk: a byte stays in ST_SCMP for each fallback it
// takes, at most the matched length. The first byte of a text also builds
// the table in ST_BINIT, ST_BLOAD and ST_BCMP. Once found, each byte skips
// the walk and goes straight to ST_DONE. The result register lets the next
// byte enter while a result waits; the last-of-text byte clears match state.
// Register writes are always taken and apply from the next text on.
// ----------------------------------------------------------------------------
module kmp_substring_match
(
    input  logic     clk,
    input  logic     rst_n,
    kmp_text_if.sink     text,
    kmp_result_if.source result,
    kmp_cfg_if.sink      cfg
);
    import kmp_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,    // ready for a text byte
        ST_BINIT,   // copy pattern, clear table
        ST_BLOAD,   // fetch p[i], table[i] for next table entry
        ST_BCMP,    // border walk for table entry i+1
        ST_SCMP,    // search walk for the current byte
        ST_DONE     // hand result to the output register
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [PAT_W-1:0] cfg_pat_reg;
    logic [LEN_W-1:0] cfg_len_reg;

    // control state
    logic             table_ready_reg;
    logic             found_reg;
    logic [LEN_W-1:0] matched_reg;
    logic             res_valid_reg;

    // payload / working registers
    logic [PAT_W-1:0]  act_pat_reg;
    logic [LEN_W-1:0]  act_len_reg;
    logic [LEN_W-1:0]  tbl_reg [MAX_PATTERN];
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [LEN_W-1:0]  j_reg;
    logic [BYTE_W-1:0] pi_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              res_found_reg;
    logic              res_done_reg;

    // shared read port and comparator
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_pat;
    logic [IDX_W-1:0]  rd_tbl;
    logic [BYTE_W-1:0] cmp_a;
    logic              eq;

    logic [LEN_W-1:0]  len_clamp;
    logic              build_more;
    logic [IDX_W-1:0]  k_next;
    logic [LEN_W-1:0]  j_next;
    logic              text_txn;
    logic              cfg_txn;
    logic              out_free;

    always_comb
    begin
        unique case (state_reg)
            ST_BLOAD: rd_addr = i_reg;
            ST_SCMP:  rd_addr = j_reg[IDX_W-1:0];
            default:  rd_addr = k_reg;
        endcase
    end

    assign rd_pat = act_pat_reg[rd_addr*BYTE_W +: BYTE_W];
    assign rd_tbl = tbl_reg[rd_addr][IDX_W-1:0];
    assign cmp_a  = (state_reg == ST_SCMP) ? byte_reg : pi_reg;
    assign eq     = (cmp_a == rd_pat);

    assign len_clamp  = (cfg_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : cfg_len_reg;
    assign build_more = ({1'b0, i_reg} + LEN_W'(1)) < act_len_reg;
    assign k_next     = eq ? (k_reg + IDX_W'(1)) : k_reg;
    assign j_next     = eq ? (j_reg + LEN_W'(1)) : j_reg;

    assign text_txn = text.valid && text.ready;
    assign cfg_txn  = cfg.valid && cfg.ready;
    assign out_free = !res_valid_reg || result.ready;

    assign text.ready      = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign result.valid    = res_valid_reg;
    assign result.found    = res_found_reg;
    assign result.text_done = res_done_reg;

    // sequencer, control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cfg_pat_reg     <= '0;
            cfg_len_reg     <= '0;
            table_ready_reg <= 1'b0;
            found_reg       <= 1'b0;
            matched_reg     <= '0;
            res_valid_reg   <= 1'b0;
            res_found_reg   <= 1'b0;
            res_done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_txn)
            begin
                unique case (cfg.index)
                    REG_PATTERN_BYTES:  cfg_pat_reg <= cfg.data[PAT_W-1:0];
                    REG_PATTERN_LENGTH: cfg_len_reg <= cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (result.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (text_txn)
                    begin
                        if (!table_ready_reg)
                            state_reg <= ST_BINIT;
                        else if (found_reg)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_SCMP;
                    end
                end
                ST_BINIT:
                begin
                    matched_reg     <= '0;
                    table_ready_reg <= 1'b1;
                    if (len_clamp == '0)
                        found_reg <= 1'b1;
                    state_reg <= ST_BLOAD;
                end
                ST_BLOAD:
                begin
                    if (build_more)
                        state_reg <= ST_BCMP;
                    else if (found_reg)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_SCMP;
                end
                ST_BCMP:
                begin
                    if (!((k_reg != '0) && !eq))
                        state_reg <= ST_BLOAD;
                end
                ST_SCMP:
                begin
                    if (!((j_reg[IDX_W-1:0] != '0) && !eq))
                    begin
                        matched_reg <= j_next;
                        if (j_next >= act_len_reg)
                            found_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_found_reg <= found_reg;
                        res_done_reg  <= last_reg;
                        if (last_reg)
                        begin
                            matched_reg     <= '0;
                            found_reg       <= 1'b0;
                            table_ready_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers; no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_txn)
                begin
                    byte_reg <= text.text_byte;
                    last_reg <= text.last_of_text;
                    j_reg    <= {1'b0, matched_reg[IDX_W-1:0]};
                end
            end
            ST_BINIT:
            begin
                act_pat_reg <= cfg_pat_reg;
                act_len_reg <= len_clamp;
                i_reg       <= IDX_W'(1);
                for (int e = 0; e < MAX_PATTERN; e++)
                    tbl_reg[e] <= '0;
            end
            ST_BLOAD:
            begin
                k_reg  <= rd_tbl;
                pi_reg <= rd_pat;
                j_reg  <= '0;
            end
            ST_BCMP:
            begin
                if ((k_reg != '0) && !eq)
                    k_reg <= rd_tbl;
                else
                begin
                    tbl_reg[i_reg + IDX_W'(1)] <= {1'b0, k_next};
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
            ST_SCMP:
            begin
                if ((j_reg[IDX_W-1:0] != '0) && !eq)
                    j_reg <= {1'b0, rd_tbl};
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/kmp_checker.sv -----
// ----------------------------------------------------------------------------
// KMP search checker
// Port-level assertions on transaction order and result stability.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmp_checker
(
    input logic clk,
    input logic rst_n,
    input logic text_valid,
    input logic text_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_found,
    input logic res_done
);
    logic       text_txn;
    logic       res_txn;
    logic [1:0] pend_reg;
    logic       sticky_reg;

    assign text_txn = text_valid && text_ready;
    assign res_txn  = res_valid && res_ready;

    // bytes accepted whose result has not been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, text_txn} - {1'b0, res_txn};
            if (res_txn)
                sticky_reg <= res_found && !res_done;
        end
    end

    // one byte in work, one result held
    `ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= 2'd2)
    // a result never appears without a byte behind it
    `ASSERT_IMP(a_no_spurious, clk, rst_n, res_valid, pend_reg != 2'd0)
    // found is sticky within a text
    `ASSERT_IMP(a_found_sticky, clk, rst_n, res_txn && sticky_reg, res_found)
    // the block is busy right after taking a byte
    `ASSERT_NXT(a_busy_after_txn, clk, rst_n, text_txn, !text_ready)
    // a stalled result holds
    `ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_found) && $stable(res_done))

endmodule

bind kmp_substring_match kmp_checker u_kmp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_found  (result.found),
    .res_done   (result.text_done)
);
